FILE: design/dfs_pkg.sv
// Shared codes for the depth-first traversal stepper: actions, events, colors
// and default sizes. No dependencies.
package dfs_pkg;

  localparam int unsigned DefMaxVertices = 64;
  localparam int unsigned DefMaxEdges    = 256;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_STEP    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    EV_ACK      = 3'd0,
    EV_DISCOVER = 3'd1,
    EV_EXAMINE  = 3'd2,
    EV_TREE     = 3'd3,
    EV_NONTREE  = 3'd4,
    EV_FINISH   = 3'd5,
    EV_DONE     = 3'd6,
    EV_ERROR    = 3'd7
  } event_e;

  typedef enum logic [1:0] {
    COL_WHITE = 2'd0,
    COL_GRAY  = 2'd1,
    COL_BLACK = 2'd2
  } color_e;

  typedef struct packed {
    event_e     kind;
    logic [5:0] from;
    logic [5:0] to;
  } result_t;

endpackage

FILE: design/dfs_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module dfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/dfs_traversal_event_stepper.sv
// Depth-first traversal event stepper, top level.
// Depends on dfs_pkg and dfs_ram.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command item:
//   action_i selects clear graph, add edge, restart or step; from_vertex_i
//   and to_vertex_i give the edge for add. Every item yields exactly one
//   result item on the output channel (out_valid_o / out_ready_i):
//   event_kind_o, event_from_o, event_to_o.
//   cfg_we_i / cfg_wdata_i write vertex_count; a write restarts the walk
//   (colors to white, empty stack, root scan at vertex 0), graph is kept.
// Path from accept to result loaded in the output register, by state:
//   clear, restart, discover, finish without pop, rejected add: IDLE, EMIT.
//   add edge: IDLE, ADD_LINK, EMIT; examine: IDLE, WALK_RD, EMIT; finish
//   with pop: IDLE, POP, EMIT. tree/non-tree: IDLE, CLS_RD (edge read),
//   CLS_CHK (color read), EMIT; tree adds PUSH for the head-of-list read of
//   the pushed vertex. root seek: SCAN_RD and SCAN_CHK per vertex scanned,
//   then PUSH, as the color memory read is registered.
//   One item is in flight at a time; the next is taken once the result sits
//   in the output register. A stalled receiver holds the result there; the
//   following item is still worked off, then its result and the input wait.
// Reset: empty graph, all white, vertex_count = 1, no result pending.
module dfs_traversal_event_stepper
  import dfs_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = DefMaxVertices,
  parameter int unsigned MAX_EDGES    = DefMaxEdges
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [5:0] from_vertex_i,
  input  logic [5:0] to_vertex_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_kind_o,
  output logic [5:0] event_from_o,
  output logic [5:0] event_to_o
);

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned EW  = $clog2(MAX_EDGES);
  localparam int unsigned CW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned DW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned NCW = (DW > 7) ? DW : 7;
  localparam int unsigned SW  = VW + CW;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_ADD_LINK = 10'b0000000010,
    S_SCAN_RD  = 10'b0000000100,
    S_SCAN_CHK = 10'b0000001000,
    S_PUSH     = 10'b0000010000,
    S_WALK_RD  = 10'b0000100000,
    S_CLS_RD   = 10'b0001000000,
    S_CLS_CHK  = 10'b0010000000,
    S_POP      = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } state_e;

  typedef enum logic [3:0] {
    PH_SEEK     = 4'b0001,
    PH_DISCOVER = 4'b0010,
    PH_WALK     = 4'b0100,
    PH_CLASSIFY = 4'b1000
  } phase_e;

  localparam logic [CW-1:0] CurNull = CW'(MAX_EDGES);

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [DW-1:0]     root_q, root_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic [VW-1:0]     top_v_q, top_v_d;
  logic [CW-1:0]     top_c_q, top_c_d;
  logic [CW-1:0]     edges_q, edges_d;
  logic [MAX_VERTICES-1:0] list_valid_q, list_valid_d;
  logic [MAX_VERTICES-1:0] color_valid_q, color_valid_d;
  logic [6:0]        vc_q, vc_d;
  logic [VW-1:0]     cur_v_q, cur_v_d;
  logic              seek_push_q, seek_push_d;
  logic [5:0]        cmd_from_q, cmd_from_d;
  logic [5:0]        cmd_to_q, cmd_to_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // memory ports
  logic          et_we, en_we, hd_we, tl_we, col_we, stk_we;
  logic [EW-1:0] et_waddr, en_waddr, et_raddr;
  logic [VW-1:0] et_wdata, et_rdata;
  logic [CW-1:0] en_wdata, en_rdata;
  logic [VW-1:0] hd_waddr, hd_raddr, tl_waddr, tl_raddr;
  logic [EW-1:0] hd_wdata, hd_rdata, tl_wdata, tl_rdata;
  logic [VW-1:0] col_waddr, col_raddr;
  logic [1:0]    col_wdata, col_rdata;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;

  logic [NCW-1:0] n_eff;
  logic           in_acc;
  logic           col_white;
  logic           edge_live;

  assign n_eff = (NCW'(vc_q) > NCW'(MAX_VERTICES)) ? NCW'(MAX_VERTICES) : NCW'(vc_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign edge_live  = (top_c_q < edges_q);

  dfs_ram #(.Width(VW), .Depth(MAX_EDGES)) u_edge_target (
    .clk_i, .we_i(et_we), .waddr_i(et_waddr), .wdata_i(et_wdata),
    .raddr_i(et_raddr), .rdata_o(et_rdata));
  dfs_ram #(.Width(CW), .Depth(MAX_EDGES)) u_edge_next (
    .clk_i, .we_i(en_we), .waddr_i(en_waddr), .wdata_i(en_wdata),
    .raddr_i(et_raddr), .rdata_o(en_rdata));
  dfs_ram #(.Width(EW), .Depth(MAX_VERTICES)) u_list_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_waddr), .wdata_i(hd_wdata),
    .raddr_i(hd_raddr), .rdata_o(hd_rdata));
  dfs_ram #(.Width(EW), .Depth(MAX_VERTICES)) u_list_tail (
    .clk_i, .we_i(tl_we), .waddr_i(tl_waddr), .wdata_i(tl_wdata),
    .raddr_i(tl_raddr), .rdata_o(tl_rdata));
  dfs_ram #(.Width(2), .Depth(MAX_VERTICES)) u_color (
    .clk_i, .we_i(col_we), .waddr_i(col_waddr), .wdata_i(col_wdata),
    .raddr_i(col_raddr), .rdata_o(col_rdata));
  dfs_ram #(.Width(SW), .Depth(MAX_VERTICES)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata));

  // An entry without its valid bit reads as white.
  assign col_white = !color_valid_q[cur_v_q] || (col_rdata == COL_WHITE);

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    root_d        = root_q;
    depth_d       = depth_q;
    top_v_d       = top_v_q;
    top_c_d       = top_c_q;
    edges_d       = edges_q;
    list_valid_d  = list_valid_q;
    color_valid_d = color_valid_q;
    vc_d          = vc_q;
    cur_v_d       = cur_v_q;
    seek_push_d   = seek_push_q;
    cmd_from_d    = cmd_from_q;
    cmd_to_d      = cmd_to_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;

    et_we = 1'b0; et_waddr = EW'(edges_q); et_wdata = VW'(to_vertex_i);
    et_raddr = EW'(top_c_q);
    en_we = 1'b0; en_waddr = EW'(edges_q); en_wdata = CurNull;
    hd_we = 1'b0; hd_waddr = VW'(cmd_from_q); hd_wdata = EW'(edges_q);
    hd_raddr = cur_v_q;
    tl_we = 1'b0; tl_waddr = VW'(cmd_from_q); tl_wdata = EW'(edges_q);
    tl_raddr = VW'(from_vertex_i);
    col_we = 1'b0; col_waddr = top_v_q; col_wdata = COL_GRAY;
    col_raddr = VW'(root_q);
    stk_we = 1'b0; stk_waddr = VW'(depth_q - DW'(1)); stk_wdata = {top_v_q, top_c_q};
    stk_raddr = VW'(depth_q - DW'(2));

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (action_e'(action_i)) inside
            ACT_CLEAR, ACT_RESTART: begin
              if (action_e'(action_i) == ACT_CLEAR) begin
                list_valid_d = '0;
                edges_d      = '0;
              end
              color_valid_d = '0;
              depth_d = '0;
              root_d  = '0;
              phase_d = PH_SEEK;
              res_d   = '{kind: EV_ACK, from: 6'd0, to: 6'd0};
              state_d = S_EMIT;
            end
            ACT_ADD: begin
              res_d = '{kind: EV_ERROR, from: from_vertex_i, to: to_vertex_i};
              if (NCW'(from_vertex_i) >= n_eff || NCW'(to_vertex_i) >= n_eff ||
                  edges_q >= CW'(MAX_EDGES)) begin
                state_d = S_EMIT;
              end else begin
                // store the new edge as a list end; link it next cycle
                color_valid_d = '0;
                depth_d = '0;
                root_d  = '0;
                phase_d = PH_SEEK;
                et_we = 1'b1;
                en_we = 1'b1;
                cmd_from_d = from_vertex_i;
                cmd_to_d   = to_vertex_i;
                state_d = S_ADD_LINK;
              end
            end
            default: begin
              if (phase_q == PH_SEEK) begin
                state_d = S_SCAN_RD;
              end else if (phase_q == PH_DISCOVER) begin
                col_we = 1'b1;
                color_valid_d[top_v_q] = 1'b1;
                phase_d = PH_WALK;
                res_d = '{kind: EV_DISCOVER, from: 6'(top_v_q), to: 6'd0};
                state_d = S_EMIT;
              end else if (edge_live) begin
                // edge target and next come back next cycle
                state_d = (phase_q == PH_WALK) ? S_WALK_RD : S_CLS_RD;
              end else begin
                // no edge left: finish the top vertex and pop
                col_we = 1'b1;
                col_wdata = COL_BLACK;
                color_valid_d[top_v_q] = 1'b1;
                depth_d = depth_q - DW'(1);
                res_d = '{kind: EV_FINISH, from: 6'(top_v_q), to: 6'd0};
                if (depth_q > DW'(1)) begin
                  phase_d = PH_WALK;
                  state_d = S_POP;
                end else begin
                  phase_d = PH_SEEK;
                  state_d = S_EMIT;
                end
              end
            end
          endcase
        end
      end
      S_ADD_LINK: begin
        if (list_valid_q[VW'(cmd_from_q)]) begin
          en_we    = 1'b1;
          en_waddr = tl_rdata;
          en_wdata = edges_q;
        end else begin
          hd_we = 1'b1;
        end
        tl_we = 1'b1;
        list_valid_d[VW'(cmd_from_q)] = 1'b1;
        edges_d = edges_q + CW'(1);
        res_d = '{kind: EV_ACK, from: cmd_from_q, to: cmd_to_q};
        state_d = S_EMIT;
      end
      S_SCAN_RD: begin
        cur_v_d = VW'(root_q);
        if (NCW'(root_q) >= n_eff) begin
          res_d = '{kind: EV_DONE, from: 6'd0, to: 6'd0};
          state_d = S_EMIT;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        root_d = root_q + DW'(1);
        if (col_white) begin
          seek_push_d = 1'b1;
          state_d = S_PUSH;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_PUSH: begin
        if (depth_q != '0) begin
          stk_we = 1'b1;
        end
        top_v_d = cur_v_q;
        top_c_d = list_valid_q[cur_v_q] ? CW'(hd_rdata) : CurNull;
        depth_d = depth_q + DW'(1);
        if (seek_push_q) begin
          col_we = 1'b1;
          col_waddr = cur_v_q;
          color_valid_d[cur_v_q] = 1'b1;
          phase_d = PH_WALK;
          res_d = '{kind: EV_DISCOVER, from: 6'(cur_v_q), to: 6'd0};
        end else begin
          phase_d = PH_DISCOVER;
        end
        state_d = S_EMIT;
      end
      S_WALK_RD: begin
        phase_d = PH_CLASSIFY;
        res_d = '{kind: EV_EXAMINE, from: 6'(top_v_q), to: 6'(et_rdata)};
        state_d = S_EMIT;
      end
      S_CLS_RD: begin
        // advance the cursor, then look up the target's color
        top_c_d = en_rdata;
        cur_v_d = et_rdata;
        col_raddr = et_rdata;
        state_d = S_CLS_CHK;
      end
      S_CLS_CHK: begin
        if (col_white && depth_q < DW'(MAX_VERTICES)) begin
          seek_push_d = 1'b0;
          res_d = '{kind: EV_TREE, from: 6'(top_v_q), to: 6'(cur_v_q)};
          state_d = S_PUSH;
        end else begin
          phase_d = PH_WALK;
          res_d = '{kind: EV_NONTREE, from: 6'(top_v_q), to: 6'(cur_v_q)};
          state_d = S_EMIT;
        end
      end
      S_POP: begin
        {top_v_d, top_c_d} = stk_rdata;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d = res_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // register write: keep the graph, restart the walk
    if (cfg_we_i) begin
      vc_d = cfg_wdata_i;
      color_valid_d = '0;
      depth_d = '0;
      root_d  = '0;
      phase_d = PH_SEEK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      phase_q       <= PH_SEEK;
      root_q        <= '0;
      depth_q       <= '0;
      edges_q       <= '0;
      list_valid_q  <= '0;
      color_valid_q <= '0;
      vc_q          <= 7'd1;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      root_q        <= root_d;
      depth_q       <= depth_d;
      edges_q       <= edges_d;
      list_valid_q  <= list_valid_d;
      color_valid_q <= color_valid_d;
      vc_q          <= vc_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_v_q     <= top_v_d;
    top_c_q     <= top_c_d;
    cur_v_q     <= cur_v_d;
    seek_push_q <= seek_push_d;
    cmd_from_q  <= cmd_from_d;
    cmd_to_q    <= cmd_to_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_q.kind;
  assign event_from_o = out_q.from;
  assign event_to_o   = out_q.to;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MAX_VERTICES))
    else $error("stack depth beyond vertex capacity");

  a_edges_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edges_q <= CW'(MAX_EDGES))
    else $error("edge count beyond store capacity");

  a_walk_has_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && phase_q != PH_SEEK) |-> depth_q != '0)
    else $error("walk phase with empty stack");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted item produced no work");
`endif

endmodule
